>>> src/lnhf_pkg.sv
// lnhf_pkg: shared types, constants and prefix tables of the line normalize header filter
package lnhf_pkg;

  localparam int HOLD_DEPTH = 17;
  localparam int CNT_W = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int LEN_STAT = 17;
  localparam int LEN_STAT2 = 18;
  localparam int LEN_ENV = 7;

  localparam logic [7:0] CHR_CR = 8'h0d;
  localparam logic [7:0] CHR_LF = 8'h0a;
  localparam logic [7:0] CHR_COLON = 8'h3a;

  // longer status prefix in lower case, the shorter one ends with a colon after 16 chars
  localparam logic [7:0] PFX_STAT [LEN_STAT2] = '{
    8'h78, 8'h2d, 8'h6d, 8'h6f, 8'h7a, 8'h69, 8'h6c, 8'h6c, 8'h61,
    8'h2d, 8'h73, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h32, 8'h3a
  };

  // envelope prefix, case sensitive
  localparam logic [7:0] PFX_ENV [LEN_ENV] = '{
    8'h46, 8'h72, 8'h6f, 8'h6d, 8'h20, 8'h2d, 8'h20
  };

  typedef enum logic [1:0] {
    MODE_DECIDE = 2'd0,
    MODE_KEEP   = 2'd1,
    MODE_DROP   = 2'd2
  } line_mode_e;

  typedef enum logic [1:0] {
    PH_FLUSH = 2'd0,
    PH_BYTE  = 2'd1,
    PH_CR    = 2'd2,
    PH_LF    = 2'd3
  } phase_e;

  // work for the back end: flush cnt held bytes, then the byte or a line end
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             eol;
    logic [7:0]       data;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] rd_idx;
    logic             flush_done;
  } back_status_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> src/lnhf_in_if.sv
// lnhf_in_if: raw byte request channel
interface lnhf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> src/lnhf_out_if.sv
// lnhf_out_if: filtered byte request channel
interface lnhf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

>>> src/line_normalize_header_filter.sv
// line_normalize_header_filter: top level of the line end normalizer and header line filter
//
// in_i takes one raw byte per request; out_o gives the filtered stream one byte per
// request, run_last set on the last byte caused by one input byte. crlf_we_i with
// crlf_wdata_i sets the line end style: 1 gives CR LF, 0 gives LF.
// Throughput: one input byte per cycle while in_i.ready is high. A byte that is kept or a
// line end of a kept line gives its output bytes in turn; a line whose first bytes were
// held also emits its held bytes (up to 17) when it is released.
// An accepted byte goes through the command queue and the output register to out_o.
// The front end classifies bytes and queues commands; the back end emits them. While
// a release of held bytes is still pending, a new line waits at its first byte, since
// the held store is read by the back end during the release.
// When the receiver stalls, the output register holds, the queue fills and then
// in_i.ready drops; nothing is lost.
// Reset (rst_ni low) clears the line state, the queue and the output register and
// sets the LF line end style.
module line_normalize_header_filter #(
  parameter int QueueDepth = lnhf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        crlf_we_i,
  input  logic        crlf_wdata_i,
  lnhf_in_if.sink     in_i,
  lnhf_out_if.source  out_o
);
  import lnhf_pkg::*;

  logic         crlf_q;
  logic         push;
  cmd_t         cmd;
  logic         q_full;
  logic         head_valid;
  cmd_t         head;
  logic         pop;
  back_status_t sts;
  logic [7:0]   rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_q <= 1'b0;
    end else if (crlf_we_i) begin
      crlf_q <= crlf_wdata_i;
    end
  end

  lnhf_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (cmd),
    .sts_i     (sts),
    .rd_data_o (rd_data)
  );

  lnhf_cmd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  lnhf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .crlf_i       (crlf_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .sts_o        (sts),
    .rd_data_i    (rd_data),
    .out_o        (out_o)
  );

endmodule

>>> src/lnhf_front.sv
// lnhf_front: line splitting, prefix classification and held byte store
module lnhf_front #(
  parameter int QueueDepth = lnhf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lnhf_in_if.sink              in_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lnhf_pkg::cmd_t       cmd_o,
  input  lnhf_pkg::back_status_t sts_i,
  output logic [7:0]           rd_data_o
);
  import lnhf_pkg::*;

  localparam int PendW = $clog2(QueueDepth + 2);

  logic [7:0]       held_q [HOLD_DEPTH];
  logic [CNT_W-1:0] held_cnt_q, held_cnt_d;
  logic [2:0]       live_q, live_d;
  line_mode_e       mode_q, mode_d;
  logic             after_cr_q, after_cr_d;
  logic [PendW-1:0] pend_q, pend_d;

  logic             accept;
  logic             held_we;
  logic [7:0]       b;
  logic [7:0]       got_f;
  logic [7:0]       want0, want1, want2;
  logic [2:0]       hit;
  logic             fin;
  logic [CNT_W-1:0] p;
  logic             deciding;
  logic             pend_inc;

  assign deciding = (mode_q != MODE_KEEP) && (mode_q != MODE_DROP);
  assign in_i.ready = !q_full_i && !((pend_q != '0) && deciding);
  assign accept = in_i.valid && in_i.ready;
  assign b = in_i.in_byte;
  assign p = held_cnt_q;
  assign got_f = lower_ascii(b);

  always_comb begin
    want0 = '0;
    want1 = '0;
    want2 = '0;
    if (p == CNT_W'(LEN_STAT - 1)) begin
      want0 = CHR_COLON;
    end else if (p < CNT_W'(LEN_STAT)) begin
      want0 = PFX_STAT[p];
    end
    if (p < CNT_W'(LEN_STAT2)) begin
      want1 = PFX_STAT[p];
    end
    if (p < CNT_W'(LEN_ENV)) begin
      want2 = PFX_ENV[p[2:0]];
    end
    hit[0] = live_q[0] && (p < CNT_W'(LEN_STAT)) && (got_f == want0);
    hit[1] = live_q[1] && (p < CNT_W'(LEN_STAT2)) && (got_f == want1);
    hit[2] = live_q[2] && (p < CNT_W'(LEN_ENV)) && (b == want2);
    fin = (hit[0] && (p == CNT_W'(LEN_STAT - 1))) ||
          (hit[1] && (p == CNT_W'(LEN_STAT2 - 1))) ||
          (hit[2] && (p == CNT_W'(LEN_ENV - 1)));
  end

  always_comb begin
    held_cnt_d = held_cnt_q;
    live_d = live_q;
    mode_d = mode_q;
    after_cr_d = after_cr_q;
    held_we = 1'b0;
    push_o = 1'b0;
    cmd_o.cnt = '0;
    cmd_o.eol = 1'b0;
    cmd_o.data = b;
    if (accept) begin
      after_cr_d = (b == CHR_CR);
      if (after_cr_q && b == CHR_LF) begin
        after_cr_d = 1'b0;
      end else if (b == CHR_CR || b == CHR_LF) begin
        if (mode_q != MODE_DROP) begin
          push_o = 1'b1;
          cmd_o.eol = 1'b1;
          cmd_o.cnt = (mode_q == MODE_KEEP) ? '0 : held_cnt_q;
        end
        held_cnt_d = '0;
        live_d = 3'b111;
        mode_d = MODE_DECIDE;
      end else begin
        case (mode_q)
          MODE_KEEP: begin
            push_o = 1'b1;
          end
          MODE_DROP: begin
          end
          default: begin
            live_d = hit;
            if (fin) begin
              mode_d = MODE_DROP;
              held_cnt_d = '0;
            end else if (hit == 3'b000 || p >= CNT_W'(HOLD_DEPTH)) begin
              push_o = 1'b1;
              cmd_o.cnt = held_cnt_q;
              mode_d = MODE_KEEP;
              held_cnt_d = '0;
            end else begin
              held_we = 1'b1;
              held_cnt_d = p + CNT_W'(1);
            end
          end
        endcase
      end
    end
  end

  assign pend_inc = push_o && (cmd_o.cnt != '0);

  always_comb begin
    pend_d = pend_q;
    if (pend_inc && !sts_i.flush_done) begin
      pend_d = pend_q + PendW'(1);
    end else if (!pend_inc && sts_i.flush_done) begin
      pend_d = pend_q - PendW'(1);
    end
  end

  assign rd_data_o = (sts_i.rd_idx < CNT_W'(HOLD_DEPTH)) ? held_q[sts_i.rd_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      live_q <= 3'b111;
      mode_q <= MODE_DECIDE;
      after_cr_q <= 1'b0;
      pend_q <= '0;
    end else begin
      held_cnt_q <= held_cnt_d;
      live_q <= live_d;
      mode_q <= mode_d;
      after_cr_q <= after_cr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[p] <= b;
    end
  end

endmodule

>>> src/lnhf_cmd_queue.sv
// lnhf_cmd_queue: short fifo of commands between front and back end
module lnhf_cmd_queue #(
  parameter int Depth = lnhf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lnhf_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           head_valid_o,
  output lnhf_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import lnhf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> src/lnhf_back.sv
// lnhf_back: command sequencer that emits flushed, kept and line end bytes
module lnhf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   crlf_i,
  input  logic                   head_valid_i,
  input  lnhf_pkg::cmd_t         head_i,
  output logic                   pop_o,
  output lnhf_pkg::back_status_t sts_o,
  input  logic [7:0]             rd_data_i,
  lnhf_out_if.source             out_o
);
  import lnhf_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             busy_q, busy_d;
  cmd_t             cur_q, cur_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  cmd_t             job;
  phase_e           ph, ph_nxt;
  logic [CNT_W-1:0] idx;
  logic [CNT_W:0]   idx_inc;
  logic             flush_more;
  logic             more;
  logic             adv;
  logic             fire;
  logic [7:0]       byte_sel;

  assign adv = !out_valid_q || out_o.ready;
  assign fire = adv && (busy_q || head_valid_i);
  assign pop_o = fire && !busy_q;

  // current phase, or the first phase of the head command
  always_comb begin
    job = busy_q ? cur_q : head_i;
    if (busy_q) begin
      ph = phase_q;
      idx = idx_q;
    end else begin
      idx = '0;
      if (head_i.cnt != '0) begin
        ph = PH_FLUSH;
      end else if (!head_i.eol) begin
        ph = PH_BYTE;
      end else if (crlf_i) begin
        ph = PH_CR;
      end else begin
        ph = PH_LF;
      end
    end
  end

  assign idx_inc = {1'b0, idx} + (CNT_W + 1)'(1);
  assign flush_more = idx_inc < {1'b0, job.cnt};

  // next phase
  always_comb begin
    ph_nxt = ph;
    more = 1'b0;
    unique case (ph)
      PH_FLUSH: begin
        more = 1'b1;
        if (flush_more) begin
          ph_nxt = PH_FLUSH;
        end else if (!job.eol) begin
          ph_nxt = PH_BYTE;
        end else if (crlf_i) begin
          ph_nxt = PH_CR;
        end else begin
          ph_nxt = PH_LF;
        end
      end
      PH_BYTE: begin
        more = 1'b0;
      end
      PH_CR: begin
        more = 1'b1;
        ph_nxt = PH_LF;
      end
      PH_LF: begin
        more = 1'b0;
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  // emitted byte
  always_comb begin
    unique case (ph)
      PH_FLUSH: byte_sel = rd_data_i;
      PH_BYTE:  byte_sel = job.data;
      PH_CR:    byte_sel = CHR_CR;
      PH_LF:    byte_sel = CHR_LF;
      default:  byte_sel = CHR_LF;
    endcase
  end

  assign sts_o.rd_idx = idx;
  assign sts_o.flush_done = fire && (ph == PH_FLUSH) && !flush_more;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    busy_d = busy_q;
    cur_d = cur_q;
    phase_d = phase_q;
    idx_d = idx_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_byte_d = byte_sel;
      out_last_d = !more;
      busy_d = more;
      cur_d = job;
      phase_d = ph_nxt;
      idx_d = (ph == PH_FLUSH && flush_more) ? idx_inc[CNT_W-1:0] : idx;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q <= 1'b0;
      phase_q <= PH_FLUSH;
      idx_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q <= busy_d;
      phase_q <= phase_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    cur_q <= cur_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.run_last = out_last_q;

endmodule

>>> sim/line_normalize_header_filter_tb.sv
// testbench for line_normalize_header_filter: random byte streams checked against a line predictor
`timescale 1ns / 100ps

module line_normalize_header_filter_tb;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int MAX_REPORTS = 10;
  localparam int HELD_MAX = 17;
  localparam int NUM_PHASES = 4;

  typedef enum int {
    PFX_STATUS   = 0,
    PFX_STATUS2  = 1,
    PFX_ENVELOPE = 2
  } prefix_e;

  // header prefixes, the status ones in lower case, zero padded
  localparam logic [7:0] PREFIX_TXT [3][18] = '{
    '{8'h78, 8'h2d, 8'h6d, 8'h6f, 8'h7a, 8'h69, 8'h6c, 8'h6c, 8'h61,
      8'h2d, 8'h73, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h3a, 8'h00},
    '{8'h78, 8'h2d, 8'h6d, 8'h6f, 8'h7a, 8'h69, 8'h6c, 8'h6c, 8'h61,
      8'h2d, 8'h73, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73, 8'h32, 8'h3a},
    '{8'h46, 8'h72, 8'h6f, 8'h6d, 8'h20, 8'h2d, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int PREFIX_LEN [3] = '{17, 18, 7};

  localparam logic [7:0] CHR_CR = 8'h0d;
  localparam logic [7:0] CHR_LF = 8'h0a;

  // empty lines, lone and doubled CR, NUL and 0xff data, short line, dropped envelope line
  localparam logic [7:0] DIRECTED [22] = '{
    8'h0a, 8'h0d, 8'h0a, 8'h0d, 8'h0d, 8'h00, 8'hff, 8'h41, 8'h0a, 8'h46, 8'h72,
    8'h0d, 8'h0a, 8'h46, 8'h72, 8'h6f, 8'h6d, 8'h20, 8'h2d, 8'h20, 8'h0d, 8'h0a
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_req_t;

  class filtered_stream_board;
    out_req_t             expected_q[$];
    logic [7:0]           held[HELD_MAX];
    int                   held_n;
    logic [2:0]           live;
    lnhf_pkg::line_mode_e mode;
    bit                   after_cr;
    bit                   crlf;
    int                   errors;

    function new();
      held_n = 0;
      live = 3'b111;
      mode = lnhf_pkg::MODE_DECIDE;
      after_cr = 1'b0;
      crlf = 1'b0;
      errors = 0;
    endfunction

    function void set_crlf(bit v);
      crlf = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(logic [7:0] d);
      out_req_t r;
      r.data = d;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void release_held();
      for (int i = 0; i < held_n; i++) begin
        emit(held[i]);
      end
    endfunction

    function void start_line();
      held_n = 0;
      live = 3'b111;
      mode = lnhf_pkg::MODE_DECIDE;
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    endfunction

    function void note_raw_byte(logic [7:0] b);
      int         n0;
      int         p;
      bit         hit;
      logic [7:0] want;
      logic [7:0] got;
      out_req_t   r;
      n0 = expected_q.size();
      if (after_cr && b == CHR_LF) begin
        after_cr = 1'b0;
        return;
      end
      after_cr = (b == CHR_CR);
      if (b == CHR_CR || b == CHR_LF) begin
        if (mode != lnhf_pkg::MODE_DROP) begin
          if (mode != lnhf_pkg::MODE_KEEP) begin
            release_held();
          end
          if (crlf) begin
            emit(CHR_CR);
          end
          emit(CHR_LF);
        end
        start_line();
      end else if (mode == lnhf_pkg::MODE_KEEP) begin
        emit(b);
      end else if (mode == lnhf_pkg::MODE_DECIDE) begin
        p = held_n;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
          if (live[k]) begin
            if (p >= PREFIX_LEN[k]) begin
              live[k] = 1'b0;
            end else begin
              want = PREFIX_TXT[k][p];
              got = b;
              if (k != PFX_ENVELOPE) begin
                want = fold(want);
                got = fold(got);
              end
              if (want != got) begin
                live[k] = 1'b0;
              end else if (p + 1 == PREFIX_LEN[k]) begin
                hit = 1'b1;
              end
            end
          end
        end
        if (hit) begin
          mode = lnhf_pkg::MODE_DROP;
          held_n = 0;
        end else if (live == 3'b000 || p >= HELD_MAX) begin
          release_held();
          emit(b);
          mode = lnhf_pkg::MODE_KEEP;
          held_n = 0;
        end else begin
          held[p] = b;
          held_n = p + 1;
        end
      end
      if (expected_q.size() > n0) begin
        r = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_out_byte(logic [7:0] data, logic last);
      out_req_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected out_byte %h run_last %b", data, last);
        end
        return;
      end
      r = expected_q.pop_front();
      if (r.data !== data || r.last !== last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected out_byte %h run_last %b, got out_byte %h run_last %b",
                   r.data, r.last, data, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic crlf_we;
  logic crlf_wdata;

  lnhf_in_if  in_bus ();
  lnhf_out_if out_bus ();

  line_normalize_header_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .crlf_we_i   (crlf_we),
    .crlf_wdata_i(crlf_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  filtered_stream_board board;
  logic [7:0]           line_q[$];
  int                   send_idle_pct;
  int                   stall_pct;
  int                   items_sent;
  int                   idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: check and stall
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_out_byte(out_bus.out_byte, out_bus.run_last);
    end
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no request moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a && $urandom_range(1) == 1) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    board.note_raw_byte(b);
    items_sent++;
  endtask

  task automatic push_prefix(input int k, input int cnt, input bit vary);
    for (int p = 0; p < cnt; p++) begin
      line_q.push_back(vary ? vary_case(PREFIX_TXT[k][p]) : PREFIX_TXT[k][p]);
    end
  endtask

  task automatic push_text(input int max_len);
    int n;
    n = $urandom_range(max_len);
    repeat (n) line_q.push_back(8'($urandom_range(126, 32)));
  endtask

  task automatic send_line();
    int kind;
    int k;
    int term;
    kind = $urandom_range(99);
    line_q.delete();
    if (kind < 20) begin
      push_prefix(PFX_STATUS, PREFIX_LEN[PFX_STATUS], 1'b1);
      push_text(6);
    end else if (kind < 35) begin
      push_prefix(PFX_STATUS2, PREFIX_LEN[PFX_STATUS2], 1'b1);
      push_text(6);
    end else if (kind < 50) begin
      push_prefix(PFX_ENVELOPE, PREFIX_LEN[PFX_ENVELOPE], 1'b0);
      push_text(6);
    end else if (kind < 65) begin
      // near miss: cut prefix, perhaps recased, then one stray byte
      k = $urandom_range(2);
      push_prefix(k, $urandom_range(PREFIX_LEN[k] - 1, 1), 1'b1);
      line_q.push_back(8'($urandom_range(126, 32)));
      push_text(4);
    end else if (kind < 85) begin
      push_text(20);
    end else begin
      repeat ($urandom_range(8)) line_q.push_back(8'($urandom_range(255)));
    end
    term = $urandom_range(9);
    if (term < 4) begin
      line_q.push_back(CHR_LF);
    end else if (term < 7) begin
      line_q.push_back(CHR_CR);
      line_q.push_back(CHR_LF);
    end else if (term < 9) begin
      line_q.push_back(CHR_CR);
    end
    foreach (line_q[i]) begin
      send_byte(line_q[i]);
    end
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_crlf(input bit v);
    crlf_we <= 1'b1;
    crlf_wdata <= v;
    @(posedge clk);
    crlf_we <= 1'b0;
    board.set_crlf(v);
  endtask

  initial begin
    int target;
    bit paused;
    board = new();
    clk = 1'b0;
    rst_n = 1'b0;
    crlf_we = 1'b0;
    crlf_wdata = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.in_byte = 8'h00;
    out_bus.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    idle_cycles = 0;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 69;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct = 33;
        end
      endcase
      if (ph > 0) begin
        settle();
      end
      write_crlf(ph % 2 == 0);
      if (ph == 0) begin
        foreach (DIRECTED[i]) begin
          send_byte(DIRECTED[i]);
        end
      end
      target = (ph + 1) * ITEMS_PER_PHASE;
      while (items_sent < target) begin
        if (ph == 1 && !paused && items_sent >= target - ITEMS_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
        send_line();
      end
    end

    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/lnhf_pkg.sv
src/lnhf_in_if.sv
src/lnhf_out_if.sv
src/lnhf_front.sv
src/lnhf_cmd_queue.sv
src/lnhf_back.sv
src/line_normalize_header_filter.sv
sim/line_normalize_header_filter_tb.sv
